// File: rtl/core/mbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit-field packer: shared types and constants
// Operation and result kind codes, the queued job word and the queue depth.
// ----------------------------------------------------------------------------
package mbfp_pkg;

  localparam logic OP_FIELD = 1'b0;
  localparam logic OP_END   = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int FRAME_CAP   = 256;
  localparam int COUNT_LIMIT = 255;
  localparam int Q_DEPTH     = 2;

  // One queued job: up to four data bytes, plus the status for an end word.
  typedef struct packed {
    logic        is_end;
    logic [2:0]  nres;
    logic [31:0] bytes;
    logic        status;
    logic [7:0]  err_idx;
    logic [8:0]  touched;
  } job_t;

endpackage

// File: rtl/core/mbfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit-field packer: front end
// Holds the frame state, places one field per word and queues the bytes it
// completes, or the flush and status of an end word.
// ----------------------------------------------------------------------------
module mbfp_front
  import mbfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int MAX_FIELDS      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        in_op,
  input  logic [5:0]  in_field_width,
  input  logic [31:0] in_field_value,
  input  logic [8:0]  frame_bytes,
  output logic        push,
  output job_t        job
);

  localparam int LIM_I = (MAX_FRAME_BYTES < FRAME_CAP) ? MAX_FRAME_BYTES : FRAME_CAP;
  localparam logic [8:0] LIM_CAP = LIM_I[8:0];
  localparam int CNT_I = ((MAX_FIELDS - 1) < COUNT_LIMIT) ? (MAX_FIELDS - 1) : COUNT_LIMIT;
  localparam logic [7:0] CNT_CAP = CNT_I[7:0];

  logic [7:0] partial_r, partial_nxt;
  logic [3:0] free_r, free_nxt;
  logic [8:0] done_r, done_nxt;
  logic [7:0] count_r, count_nxt;
  logic       failed_r, failed_nxt;
  logic [7:0] fail_idx_r, fail_idx_nxt;

  logic [8:0]  lim, rem;
  logic        room, big, w_ok, fits, do_write, short, fail, has_part;
  logic [5:0]  allowed, k, shr, shl;
  logic [39:0] contrib, stream, adv;
  logic [6:0]  pend;
  logic [2:0]  nb;
  logic [7:0]  partial_new, cnt_inc;
  logic [3:0]  free_new;

  always_comb begin
    lim      = (frame_bytes > LIM_CAP) ? LIM_CAP : frame_bytes;
    rem      = lim - done_r;
    room     = done_r < lim;
    big      = room && (rem > 9'd4);
    allowed  = room ? ({2'b00, free_r} + {rem[2:0] - 3'd1, 3'b000}) : 6'd0;
    w_ok     = (in_field_width != 6'd0) && (in_field_width <= 6'd32);
    fits     = (in_field_width == 6'd32) ||
               ((in_field_value >> in_field_width[4:0]) == 32'd0);
    do_write = w_ok && fits;
    short    = !big && (allowed < in_field_width);
    k        = do_write ? (short ? allowed : in_field_width) : 6'd0;
    fail     = !do_write || short;
    shr      = in_field_width - k;
    shl      = 6'd32 + {2'b00, free_r} - k;
    contrib  = do_write ? (({8'd0, in_field_value} >> shr) << shl) : 40'd0;
    stream   = {partial_r, 32'd0} | contrib;
    pend     = 7'd8 - {3'b000, free_r} + {1'b0, k};
    nb       = pend[5:3];
    adv      = stream << {nb, 3'b000};
    partial_new = adv[39:32];
    free_new    = 4'd8 - {1'b0, pend[2:0]};
    cnt_inc     = (count_r < CNT_CAP) ? count_r + 8'd1 : count_r;
    has_part    = free_r != 4'd8;
  end

  always_comb begin
    partial_nxt  = partial_r;
    free_nxt     = free_r;
    done_nxt     = done_r;
    count_nxt    = count_r;
    failed_nxt   = failed_r;
    fail_idx_nxt = fail_idx_r;
    push         = 1'b0;
    job          = '0;
    if (accept) begin
      if (in_op == OP_END) begin
        push         = 1'b1;
        job.is_end   = 1'b1;
        job.nres     = has_part ? 3'd2 : 3'd1;
        job.bytes    = {partial_r, 24'd0};
        job.status   = failed_r;
        job.err_idx  = failed_r ? fail_idx_r : 8'd0;
        job.touched  = done_r + {8'd0, has_part};
        partial_nxt  = 8'd0;
        free_nxt     = 4'd8;
        done_nxt     = 9'd0;
        count_nxt    = 8'd0;
        failed_nxt   = 1'b0;
        fail_idx_nxt = 8'd0;
      end else if (!failed_r) begin
        count_nxt   = cnt_inc;
        partial_nxt = partial_new;
        free_nxt    = free_new;
        done_nxt    = done_r + {6'd0, nb};
        if (fail) begin
          failed_nxt   = 1'b1;
          fail_idx_nxt = count_r;
        end
        job.nres  = nb;
        job.bytes = stream[39:8];
        push      = nb != 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= 8'd0;
      free_r     <= 4'd8;
      done_r     <= 9'd0;
      count_r    <= 8'd0;
      failed_r   <= 1'b0;
      fail_idx_r <= 8'd0;
    end else begin
      partial_r  <= partial_nxt;
      free_r     <= free_nxt;
      done_r     <= done_nxt;
      count_r    <= count_nxt;
      failed_r   <= failed_nxt;
      fail_idx_r <= fail_idx_nxt;
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r != 4'd0) && (free_r <= 4'd8))
    else $error("free bit count out of range");

endmodule

// File: rtl/core/mbfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit-field packer: job queue
// Short register queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module mbfp_queue
  import mbfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);

  job_t          store_r [Q_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == CNT_FULL;
  assign head_valid = cnt_r != '0;
  assign head_job   = store_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("push into full queue");

endmodule

// File: rtl/core/mbfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit-field packer: output sequencer
// Walks each job to the output register, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module mbfp_back
  import mbfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_frame_status,
  output logic [7:0] out_error_index,
  output logic [8:0] out_bytes_written,
  output logic       out_last_out
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       kind_r, status_r, last_r;
  logic [7:0] byte_r, err_r;
  logic [8:0] cnt_r;

  logic       load, is_last;
  logic [7:0] sel_byte;

  always_comb begin
    load    = head_valid && (!valid_r || out_ready);
    is_last = {1'b0, idx_r} == (head_job.nres - 3'd1);
    pop     = load && is_last;
    unique case (idx_r)
      2'd0:    sel_byte = head_job.bytes[31:24];
      2'd1:    sel_byte = head_job.bytes[23:16];
      2'd2:    sel_byte = head_job.bytes[15:8];
      default: sel_byte = head_job.bytes[7:0];
    endcase
    idx_nxt   = load ? (is_last ? 2'd0 : idx_r + 2'd1) : idx_r;
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      if (head_job.is_end && is_last) begin
        kind_r   <= KIND_STATUS;
        byte_r   <= 8'd0;
        status_r <= head_job.status;
        err_r    <= head_job.err_idx;
        cnt_r    <= head_job.touched;
      end else begin
        kind_r   <= KIND_DATA;
        byte_r   <= sel_byte;
        status_r <= 1'b0;
        err_r    <= 8'd0;
        cnt_r    <= 9'd0;
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_frame_status  = status_r;
  assign out_error_index   = err_r;
  assign out_bytes_written = cnt_r;
  assign out_last_out      = last_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head_job.nres))
    else $error("result index past job length");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == KIND_STATUS)) |-> last_r)
    else $error("status word not marked last");

endmodule

// File: rtl/core/msb_first_bit_field_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit-field packer
// Packs 1 to 32 bit fields, most significant bit first, into a byte frame.
//
// Channels: the in_ channel takes a field word (in_op = field) or an end
// word (in_op = end). The out_ channel returns data bytes and, for an end
// word, the flushed partial byte and a status word; out_last_out marks the
// last result of each input word. The cfg_ channel writes the frame size in
// bytes and is always ready; write it only while the block is idle.
// Path: a word's first result goes through the job queue, then the output
// register. Throughput: the sequencer sends one result per cycle unless
// stalled, at most four per word; a field completing no byte queues no
// job. A two-entry job queue sits between front end and sequencer.
// Reset: frame size returns to 256, frame state clears, no result pending.
// Receiver stall: results hold in the output register; the front end keeps
// taking words until the job queue fills, then drops in_ready.
// ----------------------------------------------------------------------------
module msb_first_bit_field_packer_unit
  import mbfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int MAX_FIELDS      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [5:0]  in_field_width,
  input  logic [31:0] in_field_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_frame_status,
  output logic [7:0]  out_error_index,
  output logic [8:0]  out_bytes_written,
  output logic        out_last_out
);

  logic [8:0] frame_bytes_r;
  logic       accept, push, pop, q_full, head_valid;
  job_t       push_job, head_job;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= 9'd256;
    end else if (cfg_valid) begin
      frame_bytes_r <= cfg_data;
    end
  end

  mbfp_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_FIELDS      (MAX_FIELDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_op          (in_op),
    .in_field_width (in_field_width),
    .in_field_value (in_field_value),
    .frame_bytes    (frame_bytes_r),
    .push           (push),
    .job            (push_job)
  );

  mbfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mbfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_job          (head_job),
    .pop               (pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_frame_status  (out_frame_status),
    .out_error_index   (out_error_index),
    .out_bytes_written (out_bytes_written),
    .out_last_out      (out_last_out)
  );

endmodule
